[rtl/hrv_pkg.sv]
// Package for the HTTP request validator: phases, error codes, byte classes.
// Also status codes, register indices and name tables; no dependencies.
package hrv_pkg;

    typedef enum logic [2:0] {
        PH_METHOD  = 3'd0,
        PH_TARGET  = 3'd1,
        PH_VERSION = 3'd2,
        PH_NAME    = 3'd3,
        PH_VALUE   = 3'd4,
        PH_BODY    = 3'd5
    } t_phase;

    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_TOO_LARGE = 4'd1;
    localparam logic [3:0] ERR_INCOMPL   = 4'd2;
    localparam logic [3:0] ERR_HDR_LARGE = 4'd3;
    localparam logic [3:0] ERR_REQ_LINE  = 4'd4;
    localparam logic [3:0] ERR_HDR_LINE  = 4'd5;
    localparam logic [3:0] ERR_NAME      = 4'd6;
    localparam logic [3:0] ERR_VALUE     = 4'd7;
    localparam logic [3:0] ERR_TE        = 4'd8;
    localparam logic [3:0] ERR_DUP_LEN   = 4'd9;
    localparam logic [3:0] ERR_BAD_LEN   = 4'd10;
    localparam logic [3:0] ERR_LEN_REQ   = 4'd11;
    localparam logic [3:0] ERR_BODY_INC  = 4'd12;
    localparam logic [3:0] ERR_TRAILING  = 4'd13;

    localparam logic [0:0] REG_MAX_HDR = 1'd0;
    localparam logic [0:0] REG_MAX_REQ = 1'd1;

    localparam logic [8:0] ST_OK        = 9'd200;
    localparam logic [8:0] ST_BAD       = 9'd400;
    localparam logic [8:0] ST_TOO_LARGE = 9'd413;
    localparam logic [8:0] ST_HDR_LARGE = 9'd431;

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_HT    = 8'h09;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_DEL   = 8'h7f;

    localparam logic [7:0] TE_NAME [17] = '{
        8'h74, 8'h72, 8'h61, 8'h6e, 8'h73, 8'h66, 8'h65, 8'h72, 8'h2d,
        8'h65, 8'h6e, 8'h63, 8'h6f, 8'h64, 8'h69, 8'h6e, 8'h67};
    localparam logic [7:0] CL_NAME [14] = '{
        8'h63, 8'h6f, 8'h6e, 8'h74, 8'h65, 8'h6e, 8'h74, 8'h2d,
        8'h6c, 8'h65, 8'h6e, 8'h67, 8'h74, 8'h68};
    localparam logic [7:0] VER_TEXT [7] = '{
        8'h48, 8'h54, 8'h54, 8'h50, 8'h2f, 8'h31, 8'h2e};

    function automatic logic tok_ok(input logic [7:0] c);
        logic r;
        r = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7a) ||
            (c >= 8'h41 && c <= 8'h5a);
        unique case (c)
            8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2a, 8'h2b, 8'h2d,
            8'h2e, 8'h5e, 8'h5f, 8'h60, 8'h7c, 8'h7e: r = 1'b1;
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic ctl_byte(input logic [7:0] c);
        return (c < 8'h20 && c != CH_HT) || c == CH_DEL;
    endfunction

endpackage

[rtl/http_request_validator.sv]
// HTTP/1.x request validator top level.
// Depends on hrv_pkg.
//
// Usage: request bytes arrive on the input channel (i_valid/o_stall), one
// transfer per byte; i_last_byte marks the final byte of a request. Exactly one
// verdict is produced per request on the output channel (o_valid/i_stall),
// carrying accepted, status code, error kind, body length and header length.
// Throughput: one byte per cycle while o_stall is low. The per-byte state
// update is a single registered pass. The transfer of the last byte loads the
// decision stage, which moves into the output register once that is free;
// o_valid is driven by the output register.
// Stall: o_stall is high while a verdict waits in the decision stage and the
// output register is held by i_stall; every byte is stalled then, not only a
// last byte. With both stages free no byte is ever stalled.
// Reset: synchronous, active low; limits return to 8192 and 1048576 header/
// request bytes, parser state is cleared and the output is emptied.
// Configuration: i_cfg_we writes register i_cfg_index with i_cfg_data at once.
module http_request_validator
    import hrv_pkg::*;
#(
    parameter int COUNT_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_accepted,
    output logic [8:0]  o_status_code,
    output logic [3:0]  o_error_kind,
    output logic [31:0] o_body_length,
    output logic [31:0] o_header_length
);

    localparam int CW = COUNT_BITS + 1;
    localparam logic [CW-1:0] LIMIT = {1'b1, {COUNT_BITS{1'b0}}};

    typedef struct packed {
        logic        bad;
        logic        ctrl;
        logic        colon0;
        logic        te;
        logic        cl;
    } t_flags;

    // limits
    logic [31:0] r_max_hdr, r_max_req;

    // parser state
    t_phase      r_phase, n_phase;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_hend, n_hend;
    logic        r_term, n_term;
    logic [1:0]  r_crlf, n_crlf;
    logic [3:0]  r_err, n_err;
    t_flags      r_lf, n_lf;
    logic [4:0]  r_nmp, n_nmp;
    logic [1:0]  r_cand, n_cand;
    logic [63:0] r_len, n_len;
    logic        r_lpres, n_lpres;
    logic [3:0]  r_fpos, n_fpos;

    // decision stage
    logic        r_d_valid;
    logic        r_d_cnt_lim, r_d_cnt_max, r_d_term, r_d_hdr_big, r_d_hend_max;
    logic [3:0]  r_d_err;
    logic        r_d_lpres, r_d_len_big, r_d_lt, r_d_gt;
    logic [31:0] r_d_len, r_d_hlen;

    // output stage
    logic        r_o_valid;
    logic        r_accepted;
    logic [8:0]  r_status;
    logic [3:0]  r_kind;
    logic [31:0] r_body, r_hlen;

    logic take;
    logic out_free;

    assign out_free = !r_o_valid || !i_stall;
    // a verdict in the decision stage will move only if output frees
    assign o_stall  = r_d_valid && !out_free;
    assign take     = i_valid && !o_stall;

    // byte processing
    logic [7:0]  c;
    logic        pending, is_lf_end;
    logic [2:0]  nxt;

    // feed: up to two feeds per byte (pending CR then c); written as a
    // function applied twice on the state vector
    typedef struct packed {
        t_phase      ph;
        t_flags      lf;
        logic [4:0]  nmp;
        logic [1:0]  cand;
        logic [63:0] len;
        logic [3:0]  fpos;
    } t_ps;

    function automatic t_ps feed(input t_ps s, input logic [7:0] ch, input logic lp);
        t_ps   o;
        logic [7:0] lc;
        logic [63:0] d, m10;
        o  = s;
        lc = (ch >= 8'h41 && ch <= 8'h5a) ? ch + 8'd32 : ch;
        d  = {60'd0, ch[3:0] - 4'd0};
        m10 = (s.len << 3) + (s.len << 1);
        unique case (s.ph)
            PH_METHOD: begin
                if (ch == CH_SP) begin
                    if (s.fpos == 4'd0) o.lf.bad = 1'b1;
                    o.ph = PH_TARGET;
                    o.fpos = 4'd0;
                end else begin
                    if (!tok_ok(ch) || (ch >= 8'h61 && ch <= 8'h7a)) o.lf.bad = 1'b1;
                    o.fpos = 4'd1;
                end
            end
            PH_TARGET: begin
                if (ch == CH_SP) begin
                    if (s.fpos == 4'd0) o.lf.bad = 1'b1;
                    o.ph = PH_VERSION;
                    o.fpos = 4'd0;
                end else begin
                    if ((s.fpos == 4'd0 && ch != CH_SLASH) || ctl_byte(ch)) o.lf.bad = 1'b1;
                    o.fpos = 4'd1;
                end
            end
            PH_VERSION: begin
                if (ch == CH_SP) o.lf.bad = 1'b1;
                else if (s.fpos < 4'd7) begin
                    if (ch != VER_TEXT[s.fpos[2:0]]) o.lf.bad = 1'b1;
                end else if (s.fpos == 4'd7) begin
                    if (ch != 8'h30 && ch != 8'h31) o.lf.bad = 1'b1;
                end else o.lf.bad = 1'b1;
                if (s.fpos < 4'd15) o.fpos = s.fpos + 4'd1;
            end
            PH_NAME: begin
                if (ch == CH_COLON) begin
                    if (s.nmp == 5'd0) o.lf.colon0 = 1'b1;
                    if (s.cand[0] && s.nmp == 5'd17) o.lf.te = 1'b1;
                    if (s.cand[1] && s.nmp == 5'd14) begin
                        o.lf.cl = 1'b1;
                        if (!lp) o.len = 64'd0;
                    end
                    o.ph = PH_VALUE;
                    o.fpos = 4'd0;
                end else begin
                    if (!tok_ok(ch)) o.lf.bad = 1'b1;
                    if (!(s.nmp < 5'd17 && lc == TE_NAME[s.nmp])) o.cand[0] = 1'b0;
                    if (!(s.nmp < 5'd14 && lc == CL_NAME[s.nmp[3:0]])) o.cand[1] = 1'b0;
                    if (s.nmp < 5'd31) o.nmp = s.nmp + 5'd1;
                end
            end
            PH_VALUE: begin
                if (ctl_byte(ch)) o.lf.ctrl = 1'b1;
                if (s.lf.cl && !lp) begin
                    if (ch == CH_SP || ch == CH_HT) begin
                        if (s.fpos == 4'd1) o.fpos = 4'd2;
                    end else if (ch >= 8'h30 && ch <= 8'h39) begin
                        if (s.fpos >= 4'd2) o.fpos = 4'd3;
                        // len * 10 + d would pass 2^64 - 1
                        else if (s.len > 64'h1999_9999_9999_9999 ||
                                 (s.len == 64'h1999_9999_9999_9999 && d > 64'd5))
                            o.fpos = 4'd3;
                        else begin
                            o.len = m10 + d;
                            o.fpos = 4'd1;
                        end
                    end else o.fpos = 4'd3;
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    t_ps s0, s1, s2;

    always_comb begin
        c         = i_data_byte;
        pending   = (r_crlf == 2'd1 || r_crlf == 2'd3);
        is_lf_end = (c == CH_LF) && pending;
        if (c == CH_CR) nxt = (r_crlf == 2'd2) ? 3'd3 : 3'd1;
        else if (is_lf_end) nxt = {1'b0, r_crlf} + 3'd1;
        else nxt = 3'd0;

        s0 = '{ph: r_phase, lf: r_lf, nmp: r_nmp, cand: r_cand, len: r_len, fpos: r_fpos};
        s1 = pending ? feed(s0, CH_CR, r_lpres) : s0;
        s2 = (c != CH_CR) ? feed(s1, c, r_lpres) : s1;

        n_cnt   = (r_cnt < LIMIT) ? r_cnt + CW'(1) : r_cnt;
        n_phase = r_phase;
        n_hend  = r_hend;
        n_term  = r_term;
        n_crlf  = r_crlf;
        n_err   = r_err;
        n_lf    = r_lf;
        n_nmp   = r_nmp;
        n_cand  = r_cand;
        n_len   = r_len;
        n_lpres = r_lpres;
        n_fpos  = r_fpos;

        if (r_phase != PH_BODY) begin
            if (is_lf_end) begin
                if (nxt == 3'd4) begin
                    n_term  = 1'b1;
                    n_hend  = n_cnt;
                    n_phase = PH_BODY;
                    n_crlf  = 2'd0;
                end else begin
                    if (r_phase == PH_METHOD || r_phase == PH_TARGET ||
                        r_phase == PH_VERSION) begin
                        if ((r_lf.bad || r_phase != PH_VERSION || r_fpos != 4'd8) &&
                            r_err == ERR_NONE) n_err = ERR_REQ_LINE;
                    end else if (r_phase == PH_NAME) begin
                        if (r_err == ERR_NONE) n_err = ERR_HDR_LINE;
                    end else if (r_err == ERR_NONE) begin
                        if (r_lf.colon0) n_err = ERR_HDR_LINE;
                        else if (r_lf.bad) n_err = ERR_NAME;
                        else if (r_lf.ctrl) n_err = ERR_VALUE;
                        else if (r_lf.te) n_err = ERR_TE;
                        else if (r_lf.cl) begin
                            if (r_lpres) n_err = ERR_DUP_LEN;
                            else if (r_fpos == 4'd0 || r_fpos == 4'd3) n_err = ERR_BAD_LEN;
                            else n_lpres = 1'b1;
                        end
                    end else if (r_lf.cl && !r_lf.colon0 && !r_lf.bad && !r_lf.ctrl &&
                                 !r_lf.te && !r_lpres && r_fpos != 4'd0 && r_fpos != 4'd3)
                        n_lpres = 1'b1;
                    n_phase = PH_NAME;
                    n_lf    = '0;
                    n_fpos  = 4'd0;
                    n_nmp   = 5'd0;
                    n_cand  = 2'd3;
                    n_crlf  = nxt[1:0];
                end
            end else begin
                n_phase = s2.ph;
                n_lf    = s2.lf;
                n_nmp   = s2.nmp;
                n_cand  = s2.cand;
                n_len   = s2.len;
                n_fpos  = s2.fpos;
                n_crlf  = nxt[1:0];
            end
        end
    end

    // decision stage inputs from the updated state
    logic [64:0] maxr65, hend65, len65, exp65, cnt65;
    always_comb begin
        maxr65 = {33'd0, r_max_req};
        hend65 = 65'(n_hend);
        len65  = {1'b0, n_len};
        cnt65  = 65'(n_cnt);
        exp65  = hend65 + len65;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_hdr <= 32'd8192;
            r_max_req <= 32'd1048576;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MAX_HDR: r_max_hdr <= i_cfg_data;
                REG_MAX_REQ: r_max_req <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (take && i_last_byte)) begin
            r_phase <= PH_METHOD;
            r_cnt   <= '0;
            r_hend  <= '0;
            r_term  <= 1'b0;
            r_crlf  <= 2'd0;
            r_err   <= ERR_NONE;
            r_lf    <= '0;
            r_nmp   <= 5'd0;
            r_cand  <= 2'd3;
            r_len   <= 64'd0;
            r_lpres <= 1'b0;
            r_fpos  <= 4'd0;
        end else if (take) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_hend  <= n_hend;
            r_term  <= n_term;
            r_crlf  <= n_crlf;
            r_err   <= n_err;
            r_lf    <= n_lf;
            r_nmp   <= n_nmp;
            r_cand  <= n_cand;
            r_len   <= n_len;
            r_lpres <= n_lpres;
            r_fpos  <= n_fpos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (take && i_last_byte) begin
            r_d_valid <= 1'b1;
        end else if (out_free) begin
            r_d_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_last_byte) begin
            r_d_cnt_lim  <= n_cnt >= LIMIT;
            r_d_cnt_max  <= cnt65 > maxr65;
            r_d_term     <= n_term;
            r_d_hdr_big  <= hend65 > {33'd0, r_max_hdr};
            r_d_hend_max <= hend65 > maxr65;
            r_d_err      <= n_err;
            r_d_lpres    <= n_lpres;
            r_d_len_big  <= len65 > maxr65 || exp65 > maxr65;
            r_d_lt       <= cnt65 < exp65;
            r_d_gt       <= cnt65 > exp65;
            r_d_len      <= n_len[31:0];
            r_d_hlen     <= (hend65 > 65'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : hend65[31:0];
        end
    end

    // r_d_lt/r_d_gt without length reduce to count vs header end
    logic [3:0] kind;
    logic       eq_no_len;
    assign eq_no_len = !r_d_lt && !r_d_gt;
    always_comb begin
        priority if (r_d_cnt_lim || r_d_cnt_max) kind = ERR_TOO_LARGE;
        else if (!r_d_term) kind = ERR_INCOMPL;
        else if (r_d_hdr_big) kind = ERR_HDR_LARGE;
        else if (r_d_hend_max) kind = ERR_TOO_LARGE;
        else if (r_d_err != ERR_NONE) kind = r_d_err;
        else if (!r_d_lpres) kind = eq_no_len ? ERR_NONE : ERR_LEN_REQ;
        else if (r_d_len_big) kind = ERR_TOO_LARGE;
        else if (r_d_lt) kind = ERR_BODY_INC;
        else if (r_d_gt) kind = ERR_TRAILING;
        else kind = ERR_NONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_free) begin
            r_o_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_d_valid) begin
            r_accepted <= kind == ERR_NONE;
            r_kind     <= kind;
            r_body     <= (kind == ERR_NONE) ? r_d_len : 32'd0;
            r_hlen     <= r_d_hlen;
            if (kind == ERR_NONE) r_status <= ST_OK;
            else if (kind == ERR_TOO_LARGE) r_status <= ST_TOO_LARGE;
            else if (kind == ERR_HDR_LARGE) r_status <= ST_HDR_LARGE;
            else r_status <= ST_BAD;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_accepted      = r_accepted;
    assign o_status_code   = r_status;
    assign o_error_kind    = r_kind;
    assign o_body_length   = r_body;
    assign o_header_length = r_hlen;

endmodule

[tb/http_request_validator_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for http_request_validator: drives byte streams of
// generated HTTP requests and compares each verdict with an internal parser.
// Depends on hrv_pkg and the http_request_validator RTL.
module http_request_validator_tb;
    import hrv_pkg::*;

    localparam int          COUNT_BITS  = 32;
    localparam int          CYCLE_LIMIT = 600000;
    localparam logic [7:0]  F_BAD       = 8'h01;
    localparam logic [7:0]  F_CTRL      = 8'h02;
    localparam logic [7:0]  F_COLON0    = 8'h04;
    localparam logic [7:0]  F_TE        = 8'h08;
    localparam logic [7:0]  F_CL        = 8'h10;

    typedef struct packed {
        logic        accepted;
        logic [8:0]  status_code;
        logic [3:0]  error_kind;
        logic [31:0] body_length;
        logic [31:0] header_length;
    } verdict_t;

    class hrv_scoreboard;
        logic [31:0] max_hdr;
        logic [31:0] max_req;
        t_phase      ph;
        logic [63:0] cnt;
        logic [63:0] hdr_end;
        bit          term_seen;
        int          crlf;
        logic [3:0]  first_err;
        logic [7:0]  flags;
        int          npos;
        logic [1:0]  cand;
        logic [63:0] len_val;
        bit          len_seen;
        int          fpos;
        verdict_t    pending[$];
        int          n_fail;
        int          n_verdicts;
        int          n_ok;

        function new();
            max_hdr = 32'd8192;
            max_req = 32'd1048576;
            n_fail = 0;
            n_verdicts = 0;
            n_ok = 0;
            clear();
        endfunction

        function void clear();
            ph = PH_METHOD;
            cnt = '0;
            hdr_end = '0;
            term_seen = 0;
            crlf = 0;
            first_err = ERR_NONE;
            new_line();
            ph = PH_METHOD;
            len_val = '0;
            len_seen = 0;
        endfunction

        function void new_line();
            ph = PH_NAME;
            flags = '0;
            fpos = 0;
            npos = 0;
            cand = 2'b11;
        endfunction

        function bit is_token(logic [7:0] c);
            string extra;
            extra = "!#$%&'*+-.^_`|~";
            if ((c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))
                return 1;
            for (int k = 0; k < extra.len(); k++)
                if (c == extra[k]) return 1;
            return 0;
        endfunction

        function bit is_ctl(logic [7:0] c);
            return (c < 8'h20 && c != 8'h09) || c == 8'h7f;
        endfunction

        function void note_err(logic [3:0] k);
            if (first_err == ERR_NONE) first_err = k;
        endfunction

        function void feed(logic [7:0] c);
            logic [7:0]  lc;
            logic [63:0] d;
            case (ph)
                PH_METHOD: begin
                    if (c == " ") begin
                        if (fpos == 0) flags |= F_BAD;
                        ph = PH_TARGET;
                        fpos = 0;
                    end else begin
                        if (!is_token(c) || (c >= "a" && c <= "z")) flags |= F_BAD;
                        fpos = 1;
                    end
                end
                PH_TARGET: begin
                    if (c == " ") begin
                        if (fpos == 0) flags |= F_BAD;
                        ph = PH_VERSION;
                        fpos = 0;
                    end else begin
                        if ((fpos == 0 && c != "/") || is_ctl(c)) flags |= F_BAD;
                        fpos = 1;
                    end
                end
                PH_VERSION: begin
                    if (c == " ") flags |= F_BAD;
                    else if (fpos < 7) begin
                        if (c != VER_TEXT[fpos]) flags |= F_BAD;
                    end else if (fpos == 7) begin
                        if (c != "0" && c != "1") flags |= F_BAD;
                    end else flags |= F_BAD;
                    if (fpos < 15) fpos++;
                end
                PH_NAME: begin
                    if (c == ":") begin
                        if (npos == 0) flags |= F_COLON0;
                        if (cand[0] && npos == 17) flags |= F_TE;
                        if (cand[1] && npos == 14) begin
                            flags |= F_CL;
                            if (!len_seen) len_val = '0;
                        end
                        ph = PH_VALUE;
                        fpos = 0;
                    end else begin
                        lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
                        if (!is_token(c)) flags |= F_BAD;
                        if (!(npos < 17 && lc == TE_NAME[npos])) cand[0] = 1'b0;
                        if (!(npos < 14 && lc == CL_NAME[npos])) cand[1] = 1'b0;
                        if (npos < 31) npos++;
                    end
                end
                PH_VALUE: begin
                    if (is_ctl(c)) flags |= F_CTRL;
                    if ((flags & F_CL) != 0 && !len_seen) begin
                        if (c == " " || c == 8'h09) begin
                            if (fpos == 1) fpos = 2;
                        end else if (c >= "0" && c <= "9") begin
                            d = 64'(c - "0");
                            if (fpos >= 2) fpos = 3;
                            else if (len_val > (64'hFFFF_FFFF_FFFF_FFFF - d) / 10) fpos = 3;
                            else begin
                                len_val = len_val * 10 + d;
                                fpos = 1;
                            end
                        end else fpos = 3;
                    end
                end
                default: ;
            endcase
        endfunction

        function void line_end();
            if (ph == PH_METHOD || ph == PH_TARGET || ph == PH_VERSION) begin
                if ((flags & F_BAD) != 0 || ph != PH_VERSION || fpos != 8)
                    note_err(ERR_REQ_LINE);
            end else if (ph == PH_NAME) begin
                note_err(ERR_HDR_LINE);
            end else begin
                if ((flags & F_COLON0) != 0) note_err(ERR_HDR_LINE);
                else if ((flags & F_BAD) != 0) note_err(ERR_NAME);
                else if ((flags & F_CTRL) != 0) note_err(ERR_VALUE);
                else if ((flags & F_TE) != 0) note_err(ERR_TE);
                else if ((flags & F_CL) != 0) begin
                    if (len_seen) note_err(ERR_DUP_LEN);
                    else if (fpos == 0 || fpos == 3) note_err(ERR_BAD_LEN);
                    else len_seen = 1;
                end
            end
            new_line();
        endfunction

        function void note_byte(logic [7:0] c, logic last);
            logic [63:0] cap;
            logic [63:0] maxr;
            logic [3:0]  kind;
            logic [63:0] body;
            bit          crlf_open;
            int          nxt;
            verdict_t    v;
            cap = 64'd1 << COUNT_BITS;
            maxr = {32'd0, max_req};
            if (cnt < cap) cnt++;
            if (ph != PH_BODY) begin
                crlf_open = (crlf == 1 || crlf == 3);
                if (c == 8'h0d) nxt = (crlf == 2) ? 3 : 1;
                else if (c == 8'h0a && crlf_open) nxt = crlf + 1;
                else nxt = 0;
                if (c == 8'h0a && crlf_open) begin
                    if (nxt == 4) begin
                        term_seen = 1;
                        hdr_end = cnt;
                        ph = PH_BODY;
                        crlf = 0;
                    end else begin
                        line_end();
                        crlf = nxt;
                    end
                end else begin
                    if (crlf_open) feed(8'h0d);
                    if (c != 8'h0d) feed(c);
                    crlf = nxt;
                end
            end
            if (!last) return;
            kind = ERR_NONE;
            body = '0;
            if (cnt >= cap || cnt > maxr) kind = ERR_TOO_LARGE;
            else if (!term_seen) kind = ERR_INCOMPL;
            else if (hdr_end > {32'd0, max_hdr}) kind = ERR_HDR_LARGE;
            else if (hdr_end > maxr) kind = ERR_TOO_LARGE;
            else if (first_err != ERR_NONE) kind = first_err;
            else if (!len_seen) begin
                if (cnt != hdr_end) kind = ERR_LEN_REQ;
            end else if (len_val > maxr || len_val > maxr - hdr_end) kind = ERR_TOO_LARGE;
            else if (cnt < hdr_end + len_val) kind = ERR_BODY_INC;
            else if (cnt > hdr_end + len_val) kind = ERR_TRAILING;
            else body = len_val;
            v.accepted = (kind == ERR_NONE);
            v.status_code = (kind == ERR_NONE) ? ST_OK : (kind == ERR_TOO_LARGE) ? ST_TOO_LARGE :
                            (kind == ERR_HDR_LARGE) ? ST_HDR_LARGE : ST_BAD;
            v.error_kind = kind;
            v.body_length = (kind == ERR_NONE) ? body[31:0] : 32'd0;
            v.header_length = (hdr_end > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : hdr_end[31:0];
            pending.push_back(v);
            clear();
        endfunction

        function void check(verdict_t got);
            verdict_t want;
            if (pending.size() == 0) begin
                $error("verdict with none expected: status %0d kind %0d",
                       got.status_code, got.error_kind);
                n_fail++;
                return;
            end
            want = pending.pop_front();
            n_verdicts++;
            if (want.accepted) n_ok++;
            if (got.accepted !== want.accepted) begin
                $error("accepted: expected %0d actual %0d", want.accepted, got.accepted);
                n_fail++;
            end
            if (got.status_code !== want.status_code) begin
                $error("status_code: expected %0d actual %0d", want.status_code, got.status_code);
                n_fail++;
            end
            if (got.error_kind !== want.error_kind) begin
                $error("error_kind: expected %0d actual %0d", want.error_kind, got.error_kind);
                n_fail++;
            end
            if (got.body_length !== want.body_length) begin
                $error("body_length: expected %0d actual %0d", want.body_length, got.body_length);
                n_fail++;
            end
            if (got.header_length !== want.header_length) begin
                $error("header_length: expected %0d actual %0d",
                       want.header_length, got.header_length);
                n_fail++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_data_byte;
    logic        i_last_byte;
    logic        o_valid;
    logic        i_stall;
    logic        o_accepted;
    logic [8:0]  o_status_code;
    logic [3:0]  o_error_kind;
    logic [31:0] o_body_length;
    logic [31:0] o_header_length;

    http_request_validator #(.COUNT_BITS(COUNT_BITS)) i_dut (.*);

    hrv_scoreboard sb = new();
    logic [7:0]    req_bytes[$];
    int            burst_left;
    int            bytes_sent;
    int            cycles;
    bit            hold_req;
    int            hold_cnt;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_MAX_HDR;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_data_byte = '0;
        i_last_byte = 1'b0;
        i_stall = 1'b0;
        hold_req = 0;
        hold_cnt = 0;
        burst_left = 0;
        bytes_sent = 0;
        cycles = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    // receiver: random stall, quiet stretches, and one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req = 0;
            hold_cnt = 400;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_stall <= 1'b1;
        end else if ((cycles / 64) % 3 == 0) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(0, 2) == 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check('{o_accepted, o_status_code, o_error_kind, o_body_length, o_header_length});
    end

    task automatic put_byte(input logic [7:0] c, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_data_byte <= c;
        i_last_byte <= last;
        do @(posedge i_clk); while (o_stall);
        sb.note_byte(c, last);
        bytes_sent++;
    endtask

    task automatic send_request();
        for (int k = 0; k < req_bytes.size(); k++)
            put_byte(req_bytes[k], k == req_bytes.size() - 1);
        req_bytes.delete();
    endtask

    task automatic add_str(input string s);
        for (int k = 0; k < s.len(); k++) req_bytes.push_back(s[k]);
    endtask

    task automatic send_str(input string s);
        add_str(s);
        send_request();
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        @(negedge i_clk);
        i_valid <= 1'b0;
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_MAX_HDR) sb.max_hdr = val;
        else sb.max_req = val;
    endtask

    function automatic logic [7:0] rand_print();
        return 8'($urandom_range(8'h21, 8'h7e));
    endfunction

    // builds one request; broken requests get a damaged byte, a cut or a stray CR
    task automatic build_request(input bit broken);
        int    n;
        int    len;
        int    pos;
        string name;
        bit    has_len;
        n = $urandom_range(1, 7);
        for (int k = 0; k < n; k++) req_bytes.push_back(8'($urandom_range("A", "Z")));
        if ($urandom_range(0, 19) == 0) req_bytes.push_back(8'($urandom_range("a", "z")));
        add_str(" /");
        n = $urandom_range(0, 10);
        for (int k = 0; k < n; k++) req_bytes.push_back(rand_print());
        add_str($urandom_range(0, 1) ? " HTTP/1.1\r\n" : " HTTP/1.0\r\n");
        has_len = 0;
        len = 0;
        n = $urandom_range(0, 3);
        for (int h = 0; h < n; h++) begin
            case ($urandom_range(0, 5))
                0, 1: begin
                    name = $urandom_range(0, 1) ? "Content-Length" : "CONTENT-length";
                    add_str({name, ":"});
                    if ($urandom_range(0, 1)) add_str(" ");
                    len = $urandom_range(0, 12);
                    if ($urandom_range(0, 15) == 0) add_str("184467440737095516150");
                    else if ($urandom_range(0, 15) == 0) add_str("1 2");
                    else add_str($sformatf("%0d", len));
                    if ($urandom_range(0, 1)) add_str("\t ");
                    has_len = 1;
                end
                2: begin
                    if ($urandom_range(0, 3) == 0) add_str("Transfer-Encoding: chunked");
                    else add_str("transfer-encodin: x");
                end
                default: begin
                    add_str("X-");
                    len = $urandom_range(1, 6);
                    for (int k = 0; k < len; k++)
                        req_bytes.push_back(8'($urandom_range("a", "z")));
                    add_str(": ");
                    len = $urandom_range(0, 8);
                    for (int k = 0; k < len; k++) req_bytes.push_back(rand_print());
                    len = 0;
                end
            endcase
            add_str("\r\n");
        end
        add_str("\r\n");
        len = has_len ? sb.len_val[3:0] : 0;
        n = has_len ? $urandom_range(0, 12) : ($urandom_range(0, 5) == 0);
        for (int k = 0; k < n; k++) req_bytes.push_back(8'($urandom_range(0, 255)));
        if (broken) begin
            pos = $urandom_range(0, req_bytes.size() - 1);
            case ($urandom_range(0, 2))
                0: req_bytes[pos] = 8'($urandom_range(0, 255));
                1: while (req_bytes.size() > pos + 1) void'(req_bytes.pop_back());
                default: req_bytes.insert(pos, 8'h0d);
            endcase
        end
    endtask

    task automatic run_random(input int byte_goal, input int verdict_goal);
        int start_bytes;
        int start_verdicts;
        int n;
        start_bytes = bytes_sent;
        start_verdicts = sb.n_verdicts + sb.pending.size();
        while (bytes_sent - start_bytes < byte_goal ||
               sb.n_verdicts + sb.pending.size() - start_verdicts < verdict_goal) begin
            if ($urandom_range(0, 19) == 0) begin
                n = $urandom_range(1, 10);
                for (int k = 0; k < n; k++) req_bytes.push_back(8'($urandom_range(0, 255)));
            end else begin
                build_request($urandom_range(0, 3) == 0);
            end
            send_request();
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(REG_MAX_HDR, 32'd8192);
        write_reg(REG_MAX_REQ, 32'd1048576);
        send_str("GET / HTTP/1.1\r\n\r\n");
        send_str("POST /a?b HTTP/1.0\r\ncontent-length: 3 \r\n\r\nxyz");
        send_str("get / HTTP/1.1\r\n\r\n");
        send_str("GET /\x01 HTTP/1.2\r\n\r\n");
        send_str("GET / HTTP/1.1\r\nHost\r\n\r\n");
        send_str("GET / HTTP/1.1\r\n:x\r\n\r\n");
        send_str("GET / HTTP/1.1\r\nA B: c\r\n\r\n");
        send_str("GET / HTTP/1.1\r\nA: \x7f\r\n\r\n");
        send_str("GET / HTTP/1.1\r\nTransfer-Encoding: gzip\r\n\r\n");
        send_str("GET / HTTP/1.1\r\nContent-Length: 1\r\nContent-Length: 1\r\n\r\nz");
        send_str("GET / HTTP/1.1\r\nContent-Length: 99999999999999999999\r\n\r\n");
        send_str("GET / HTTP/1.1\r\nContent-Length: 5\r\n\r\nab");
        send_str("GET / HTTP/1.1\r\nContent-Length: 1\r\n\r\nab");
        send_str("GET / HTTP/1.1\r\n\r\nzz");
        send_str("GET / HTTP/1.1\r\nA: b\rc\r\n\r\n");
        send_str("GET / HTTP/1.1\r\n");
        send_str("\xff");
        run_random(60, 2);
        wait_idle();

        write_reg(REG_MAX_HDR, 32'd4);
        write_reg(REG_MAX_REQ, 32'd4);
        send_str("\r\n\r\n");
        run_random(60, 2);
        wait_idle();

        write_reg(REG_MAX_HDR, 32'hFFFF_FFFF);
        write_reg(REG_MAX_REQ, 32'hFFFF_FFFF);
        run_random(60, 2);
        wait_idle();

        write_reg(REG_MAX_HDR, 32'd40);
        write_reg(REG_MAX_REQ, 32'd48);
        hold_req = 1;
        run_random(100, 3);
        wait_idle();

        $display("covered %0d bytes, %0d verdicts (%0d accepted) over four limit settings",
                 bytes_sent, sb.n_verdicts, sb.n_ok);
        if (sb.n_fail == 0 && sb.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
